@@ hw/rtl/shp3_pkg.sv @@
// Package for the 3x3 sharpen filter: pixel and column types, payload structs,
// register index codes and the kernel arithmetic. Depends on nothing.
package shp3_pkg;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       run_end;
		logic       frame_end;
	} pix_out_t;

	// Column of the window: px0 two rows up, px1 one row up, px2 current row.
	typedef struct packed {
		pixel_t px0;
		pixel_t px1;
		pixel_t px2;
	} column_t;

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

	localparam int MAX_RES    = 4;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;

	function automatic logic [7:0] sat_chan(input logic [7:0] ct, input logic [7:0] cm,
		input logic [7:0] cb, input logic [7:0] lm, input logic [7:0] rm);
		logic signed [11:0] s;
		s = $signed({2'b00, cm, 2'b00}) + $signed({4'b0000, cm})
			- $signed({4'b0000, ct}) - $signed({4'b0000, cb})
			- $signed({4'b0000, lm}) - $signed({4'b0000, rm});
		if (s < 0) begin
			return 8'd0;
		end else if (s > 12'sd255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

	function automatic pixel_t sharpen_px(input pixel_t ct, input pixel_t cm, input pixel_t cb,
		input pixel_t lm, input pixel_t rm);
		pixel_t r;
		for (int k = 0; k < 3; k++) begin
			r[k*8 +: 8] = sat_chan(ct[k*8 +: 8], cm[k*8 +: 8], cb[k*8 +: 8],
				lm[k*8 +: 8], rm[k*8 +: 8]);
		end
		return r;
	endfunction

	// In last-row mode the current row stands in for the missing row below.
	function automatic pixel_t emit_px(input column_t l, input column_t c, input column_t r,
		input logic last_mode, input logic y_ge1, input logic y_ge2);
		pixel_t ct;
		pixel_t cm;
		pixel_t cb;
		pixel_t lm;
		pixel_t rm;
		if (!last_mode) begin
			ct = y_ge2 ? c.px0 : c.px1;
			cm = c.px1;
			cb = c.px2;
			lm = l.px1;
			rm = r.px1;
		end else begin
			ct = y_ge1 ? c.px1 : c.px2;
			cm = c.px2;
			cb = c.px2;
			lm = l.px2;
			rm = r.px2;
		end
		return sharpen_px(ct, cm, cb, lm, rm);
	endfunction

endpackage

@@ hw/rtl/sharpen_filter_3x3.sv @@
// Streaming 3x3 sharpen filter for RGB frames in raster order.
// With the result FIFO empty, an accepted pixel is registered in stage 1 and its results
// go to the result FIFO, which offers them. Throughput: one pixel per cycle; each pixel
// yields up to four results, which leave through a 16-entry result FIFO at one per cycle.
// Input stalls when the FIFO nears full; with a sink that is always ready this happens only
// on the last row, where a pixel can yield two or more results. Line stores use one write
// port each. Reset clears counters, window and FIFO; line stores are not cleared.
module sharpen_filter_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  shp3_pkg::pix_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output shp3_pkg::pix_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_wdata
);
	import shp3_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

	logic [10:0] frame_width_q;
	logic [15:0] frame_height_q;

	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	pixel_t upper_mem [MAX_WIDTH];
	pixel_t middle_mem [MAX_WIDTH];

	logic          v_s1;
	logic [CW-1:0] idx_s1;
	pixel_t        pix_s1;
	pixel_t        up_rd_s1;
	pixel_t        mid_rd_s1;
	logic          byp_s1;
	pixel_t        fwd_up_s1;
	pixel_t        fwd_mid_s1;
	logic          x_ge1_s1;
	logic          y_ge1_s1;
	logic          y_ge2_s1;
	logic          row_end_s1;
	logic          last_s1;

	column_t win0_q;
	column_t win1_q;

	pix_out_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	logic          in_acc;
	logic          pop;
	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic          row_end;
	logic          last;
	pixel_t        pix_in;

	column_t cur;
	column_t fl;
	pixel_t  res [MAX_RES];
	logic [MAX_RES-1:0] en;
	logic [MAX_RES-1:0] is_last;
	logic [1:0]         pos [MAX_RES];
	logic [2:0]         npush;

	assign pix_in = {in_data.in_red, in_data.in_green, in_data.in_blue};

	always_comb begin
		if (frame_width_q == 11'd0) begin
			w_eff = WW'(1);
		end else if (WW'(frame_width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		h_eff   = (frame_height_q == 16'd0) ? 16'd1 : frame_height_q;
		row_end = (WW'(col_q) + WW'(1)) >= w_eff;
		last    = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
	end

	assign in_ready  = (cnt_q + (v_s1 ? (FIFO_AW+1)'(MAX_RES) : '0))
		<= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[10:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			if (in_acc) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1     <= col_q;
			pix_s1     <= pix_in;
			up_rd_s1   <= upper_mem[col_q];
			mid_rd_s1  <= middle_mem[col_q];
			byp_s1     <= v_s1 && (idx_s1 == col_q);
			fwd_up_s1  <= cur.px1;
			fwd_mid_s1 <= pix_s1;
			x_ge1_s1   <= (col_q != '0);
			y_ge1_s1   <= (row_q != 16'd0);
			y_ge2_s1   <= (row_q > 16'd1);
			row_end_s1 <= row_end;
			last_s1    <= last;
		end
		if (v_s1) begin
			upper_mem[idx_s1]  <= cur.px1;
			middle_mem[idx_s1] <= pix_s1;
		end
	end

	always_comb begin
		logic [2:0] acc;
		logic       seen;
		cur.px0 = byp_s1 ? fwd_up_s1 : up_rd_s1;
		cur.px1 = byp_s1 ? fwd_mid_s1 : mid_rd_s1;
		cur.px2 = pix_s1;
		fl      = x_ge1_s1 ? win1_q : cur;

		res[0] = emit_px(win0_q, win1_q, cur, 1'b0, y_ge1_s1, y_ge2_s1);
		res[1] = emit_px(fl, cur, cur, 1'b0, y_ge1_s1, y_ge2_s1);
		res[2] = emit_px(win0_q, win1_q, cur, 1'b1, y_ge1_s1, y_ge2_s1);
		res[3] = emit_px(fl, cur, cur, 1'b1, y_ge1_s1, y_ge2_s1);

		en[0] = v_s1 && y_ge1_s1 && x_ge1_s1;
		en[1] = v_s1 && y_ge1_s1 && row_end_s1;
		en[2] = v_s1 && last_s1 && x_ge1_s1;
		en[3] = v_s1 && last_s1 && row_end_s1;

		acc = 3'd0;
		for (int k = 0; k < MAX_RES; k++) begin
			pos[k] = acc[1:0];
			acc    = acc + {2'b00, en[k]};
		end
		npush = acc;

		seen = 1'b0;
		for (int k = MAX_RES - 1; k >= 0; k--) begin
			is_last[k] = en[k] && !seen;
			seen       = seen || en[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (v_s1) begin
			win0_q <= x_ge1_s1 ? win1_q : cur;
			win1_q <= cur;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RES; k++) begin
			if (en[k]) begin
				fifo_q[wr_ptr_q + FIFO_AW'(pos[k])] <= '{
					out_red:   res[k][23:16],
					out_green: res[k][15:8],
					out_blue:  res[k][7:0],
					run_end:   is_last[k],
					frame_end: is_last[k] && row_end_s1 && last_s1
				};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(npush);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(npush) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

@@ tb/sv/sharpen_check.sv @@
// Checker for the 3x3 sharpen filter: watches the pixel, result and register ports,
// predicts every result transaction and compares it field by field with what arrives.
// Depends on shp3_pkg for the payload, column and register index types.
module sharpen_check #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  shp3_pkg::pix_in_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  shp3_pkg::pix_out_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_wdata,
	output int                 errors,
	output int                 pending
);
	import shp3_pkg::*;

	pixel_t     upper_rows [MAX_WIDTH];
	pixel_t     middle_rows [MAX_WIDTH];
	column_t    left_col;
	column_t    center_col;
	logic [9:0] col_pos;
	logic [15:0] row_pos;
	logic [10:0] width_cfg;
	logic [15:0] height_cfg;
	pix_out_t   expected_pixels [$];
	pix_out_t   head_pixel;

	initial begin
		foreach (upper_rows[i]) begin
			upper_rows[i] = '0;
			middle_rows[i] = '0;
		end
	end

	function automatic pixel_t sharpen_point(input pixel_t above, input pixel_t centre,
		input pixel_t below, input pixel_t west, input pixel_t east);
		pixel_t res;
		int acc;
		for (int k = 0; k < 3; k++) begin
			acc = 5 * int'(centre[8*k +: 8]) - int'(above[8*k +: 8]) - int'(below[8*k +: 8])
				- int'(west[8*k +: 8]) - int'(east[8*k +: 8]);
			if (acc < 0) begin
				res[8*k +: 8] = 8'd0;
			end else if (acc > 255) begin
				res[8*k +: 8] = 8'd255;
			end else begin
				res[8*k +: 8] = acc[7:0];
			end
		end
		return res;
	endfunction

	// On the last row the current row replaces the row below, which does not exist.
	function automatic pixel_t window_result(input column_t west, input column_t mid,
		input column_t east, input logic last_row, input logic y_ge1, input logic y_ge2);
		if (!last_row) begin
			return sharpen_point(y_ge2 ? mid.px0 : mid.px1, mid.px1, mid.px2, west.px1, east.px1);
		end
		return sharpen_point(y_ge1 ? mid.px1 : mid.px2, mid.px2, mid.px2, west.px2, east.px2);
	endfunction

	task automatic predict_pixel(input pix_in_t pin);
		int       w;
		int       h;
		int       x;
		int       y;
		int       idx;
		column_t  cur;
		column_t  flush_col;
		logic     row_end;
		logic     last_row;
		logic     ge1;
		logic     ge2;
		pixel_t   outs [$];
		pix_out_t item;
		w = int'(width_cfg);
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = int'(height_cfg);
		if (h < 1) h = 1;
		x = int'(col_pos);
		y = int'(row_pos);
		idx = x % MAX_WIDTH;
		cur.px0 = upper_rows[idx];
		cur.px1 = middle_rows[idx];
		cur.px2 = pin;
		upper_rows[idx] = cur.px1;
		middle_rows[idx] = cur.px2;
		row_end = (x + 1 >= w);
		last_row = (y + 1 >= h);
		ge1 = (y >= 1);
		ge2 = (y >= 2);
		flush_col = (x >= 1) ? center_col : cur;
		if (ge1) begin
			if (x >= 1) outs.push_back(window_result(left_col, center_col, cur, 1'b0, ge1, ge2));
			if (row_end) outs.push_back(window_result(flush_col, cur, cur, 1'b0, ge1, ge2));
		end
		if (last_row) begin
			if (x >= 1) outs.push_back(window_result(left_col, center_col, cur, 1'b1, ge1, ge2));
			if (row_end) outs.push_back(window_result(flush_col, cur, cur, 1'b1, ge1, ge2));
		end
		foreach (outs[i]) begin
			item.out_red = outs[i][23:16];
			item.out_green = outs[i][15:8];
			item.out_blue = outs[i][7:0];
			item.run_end = (i == outs.size() - 1);
			item.frame_end = item.run_end && row_end && last_row;
			expected_pixels.push_back(item);
		end
		if (x == 0) begin
			left_col = cur;
			center_col = cur;
		end else begin
			left_col = center_col;
			center_col = cur;
		end
		if (row_end) begin
			col_pos = '0;
			row_pos = last_row ? 16'd0 : 16'(y + 1);
		end else begin
			col_pos = 10'(x + 1);
		end
	endtask

	task automatic report_field(input string label, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_col = '0;
			center_col = '0;
			col_pos = '0;
			row_pos = '0;
			width_cfg = FRAME_WIDTH_RST;
			height_cfg = FRAME_HEIGHT_RST;
			expected_pixels.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: result transaction expected none, actual %h", $time, out_data);
				end else begin
					head_pixel = expected_pixels.pop_front();
					report_field("out_red", int'(head_pixel.out_red), int'(out_data.out_red));
					report_field("out_green", int'(head_pixel.out_green),
						int'(out_data.out_green));
					report_field("out_blue", int'(head_pixel.out_blue), int'(out_data.out_blue));
					report_field("run_end", int'(head_pixel.run_end), int'(out_data.run_end));
					report_field("frame_end", int'(head_pixel.frame_end),
						int'(out_data.frame_end));
				end
			end
			if (in_valid && in_ready) predict_pixel(in_data);
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_WIDTH) begin
					width_cfg = cfg_wdata[10:0];
				end else begin
					height_cfg = cfg_wdata;
				end
			end
		end
		pending = expected_pixels.size();
	end

endmodule

@@ tb/sv/tb_sharpen_filter_3x3.sv @@
// Top of the sharpen filter testbench: clock, reset, pixel frames, register writes and
// random stalls on both channels, with the verdict at the end.
// Depends on shp3_pkg, sharpen_filter_3x3 and the sharpen_check module.
module tb_sharpen_filter_3x3;
	import shp3_pkg::*;

	localparam int MAX_W = 1024;

	typedef enum int {
		PAT_RANDOM,
		PAT_EXTREME,
		PAT_CHECKER,
		PAT_SMOOTH
	} pattern_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	pix_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pix_out_t    out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_FRAME_WIDTH;
	logic [15:0] cfg_wdata = '0;
	int          errors;
	int          pending;
	bit          send_burst;
	bit          take_burst;

	sharpen_filter_3x3 #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	sharpen_check #(
		.MAX_WIDTH(MAX_W)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#25_000_000;
		$display("tb_sharpen_filter_3x3: errors");
		$finish;
	end

	task automatic push_pixel(input pix_in_t p);
		int gap;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic pix_in_t make_pixel(input pattern_e style, input int x, input int y);
		pix_in_t p;
		int base;
		case (style)
			PAT_EXTREME: begin
				p.in_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.in_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			PAT_CHECKER: begin
				p = ((x + y) % 2) ? 24'hFFFFFF : 24'h000000;
			end
			PAT_SMOOTH: begin
				base = $urandom_range(96, 160);
				p.in_red = 8'(base + $urandom_range(0, 12));
				p.in_green = 8'(base + $urandom_range(0, 12));
				p.in_blue = 8'(base + $urandom_range(0, 12));
			end
			default: begin
				p = 24'($urandom);
			end
		endcase
		return p;
	endfunction

	// A nonzero cut stops the frame after that many pixels, forces the current row
	// to be the last one and finishes that row.
	task automatic run_frame(input logic [15:0] wval, input logic [15:0] hval,
		input pattern_e style, input int cut, output int fed);
		int ew;
		int eh;
		int total;
		int n;
		ew = int'(wval[10:0]);
		if (ew < 1) ew = 1;
		if (ew > MAX_W) ew = MAX_W;
		eh = int'(hval);
		if (eh < 1) eh = 1;
		total = ew * eh;
		settle();
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_FRAME_WIDTH, wval);
			write_reg(CFG_FRAME_HEIGHT, hval);
		end else begin
			write_reg(CFG_FRAME_HEIGHT, hval);
			write_reg(CFG_FRAME_WIDTH, wval);
		end
		n = 0;
		while (n < total) begin
			if (cut > 0 && n == cut) begin
				settle();
				write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(0, 1)));
				total = cut + ew - cut % ew;
			end
			push_pixel(make_pixel(style, n % ew, n / ew));
			n++;
		end
		fed = total;
	endtask

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
			stall = take_burst ? 0 : $urandom_range(0, 17);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int          fed;
		int          random_pixels;
		int          w;
		int          hv;
		int          ew;
		int          eh;
		int          cut;
		int          pick;
		logic [15:0] wval;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Reset sizes, then a mid-row shrink of the width onto the current column.
		push_pixel(24'h000000);
		push_pixel(24'hFFFFFF);
		push_pixel(24'hFF00FF);
		settle();
		write_reg(CFG_FRAME_HEIGHT, 16'd1);
		write_reg(CFG_FRAME_WIDTH, 16'd3);
		push_pixel(24'h00FF00);

		run_frame(16'd0, 16'd4, PAT_EXTREME, 0, fed);
		run_frame(16'd4, 16'd0, PAT_RANDOM, 0, fed);
		run_frame(16'd3, 16'd3, PAT_CHECKER, 0, fed);

		random_pixels = 0;
		while (random_pixels < 380) begin
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				w = 0;
			end else if (pick < 12) begin
				w = $urandom_range(1, 10);
			end else begin
				w = $urandom_range(11, 48);
			end
			hv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			wval = 16'(w);
			if ($urandom_range(0, 3) == 0) wval[15:11] = 5'($urandom);
			ew = (w == 0) ? 1 : w;
			eh = (hv == 0) ? 1 : hv;
			cut = 0;
			if (eh >= 2 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, ew * (eh - 1));
			run_frame(wval, 16'(hv), pattern_e'($urandom_range(0, 3)), cut, fed);
			random_pixels += fed;
		end

		run_frame(16'd5, 16'hFFFF, PAT_RANDOM, 12, fed);

		settle();
		if (errors == 0 && pending == 0) begin
			$display("tb_sharpen_filter_3x3: clean");
		end else begin
			$display("tb_sharpen_filter_3x3: errors");
		end
		$finish;
	end

endmodule
